/* design/ccfd_pkg.sv */
// ----------------------------------------------------------------------------
// ccfd_pkg: shared definitions of the COBS / CRC-32 frame decoder
// Result kinds, error codes, frame layout constants and the CRC step.
// ----------------------------------------------------------------------------
package ccfd_pkg;

	localparam int STORE_DEPTH_DEFAULT = 64;
	localparam int HARD_LIMIT          = 64;
	localparam int FILL_W              = 7;
	localparam int HDR_BYTES           = 5;
	localparam int MIN_FRAME           = 9;
	localparam int TRAILER_BYTES       = 4;

	localparam logic [7:0]  CODE_NO_ZERO = 8'hFF;
	localparam logic [31:0] CRC_POLY     = 32'hEDB88320;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [1:0] ERR_DOUBLE_ZERO = 2'd0;
	localparam logic [1:0] ERR_CRC         = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW    = 2'd2;

	// Four bit steps of the reflected CRC-32; a byte takes two calls.
	function automatic logic [31:0] crc_step4(input logic [31:0] c_in);
		logic [31:0] c;
		c = c_in;
		for (int j = 0; j < 4; j++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* design/cobs_crc32_frame_decoder.sv */
// ----------------------------------------------------------------------------
// cobs_crc32_frame_decoder: COBS deframer with CRC-32 check
// Unstuffs received link bytes, checks the frame CRC and replays the payload.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall / rx_byte) takes one link byte per
// transaction. A zero byte closes the frame. The output channel (out_valid /
// out_stall and the result fields) carries payload bytes, one frame summary
// or an error report; last marks the final result caused by one input byte.
// The cfg channel (cfg_valid / cfg_ready / cfg_data) writes frame_limit.
// A code byte that opens a frame is taken without a stall; every decoded
// byte passes the CRC state, since the CRC unit folds in four bits per cycle.
// At the end of a good frame the store is walked through its registered
// read: each payload byte passes ST_RD and ST_OUT, then ST_SUM gives the summary.
// in_stall stays high while a byte is being worked on or its results are
// being delivered. A stalled receiver holds the output register and the
// walk waits. Reset clears all control state and sets frame_limit to 64;
// the store needs no clearing, since a frame only reads what it wrote.
// ----------------------------------------------------------------------------
module cobs_crc32_frame_decoder import ccfd_pkg::*; #(
	parameter int FRAME_STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [7:0]  frame_id,
	output logic [31:0] timestamp,
	output logic [5:0]  payload_len,
	output logic [1:0]  error_code,
	output logic        last
);

	localparam int AW = $clog2(FRAME_STORE_DEPTH);
	localparam logic [FILL_W-1:0] LIMIT_CAP =
		FILL_W'((FRAME_STORE_DEPTH < HARD_LIMIT) ? FRAME_STORE_DEPTH : HARD_LIMIT);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CRC  = 3'd1;
	localparam logic [2:0] ST_EMIT = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [2:0] ST_SUM  = 3'd5;

	logic [2:0]        state_q;
	logic              in_frame_q;
	logic [7:0]        code_q;
	logic [7:0]        cnt_q;
	logic [31:0]       crc_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] rd_ptr_q;
	logic [6:0]        frame_limit_q;
	logic              ovf_q;
	logic              out_valid_q;
	logic [1:0]        err_q;
	logic [7:0]        hdr_q [HDR_BYTES];

	logic [1:0]  kind_q;
	logic [7:0]  data_byte_q;
	logic [7:0]  frame_id_q;
	logic [31:0] timestamp_q;
	logic [5:0]  payload_len_q;
	logic [1:0]  error_code_q;
	logic        last_q;

	logic              in_acc;
	logic              out_load;
	logic              emit;
	logic [7:0]        cnt_next;
	logic              code_hit;
	logic              do_store;
	logic [7:0]        store_val;
	logic [FILL_W-1:0] fill_inc;
	logic [FILL_W-1:0] eff_limit;
	logic              ovf;
	logic              frame_good;
	logic              walk_done;
	logic [AW+FILL_W-1:0] waddr_wide;
	logic [AW+FILL_W-1:0] raddr_wide;
	logic [7:0]        rd_data;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && (state_q == ST_IDLE);
	assign out_load  = !out_valid_q || !out_stall;
	assign emit      = out_load &&
		((state_q == ST_EMIT) || (state_q == ST_OUT) || (state_q == ST_SUM));

	assign cnt_next  = cnt_q + 8'd1;
	assign code_hit  = (cnt_next == code_q);
	// A code byte that is reached stands for a zero, unless it was 0xFF.
	assign do_store  = in_acc && in_frame_q && (rx_byte != 8'd0) &&
		(!code_hit || (code_q != CODE_NO_ZERO));
	assign store_val = code_hit ? 8'd0 : rx_byte;
	assign fill_inc  = fill_q + FILL_W'(1);
	assign eff_limit = (frame_limit_q > LIMIT_CAP) ? LIMIT_CAP : frame_limit_q;
	assign ovf       = (fill_inc >= eff_limit);
	assign frame_good = (crc_q == 32'd0) && (fill_q >= FILL_W'(MIN_FRAME));
	assign walk_done = (rd_ptr_q == fill_q - FILL_W'(TRAILER_BYTES + 1));

	assign waddr_wide = {{AW{1'b0}}, fill_q};
	assign raddr_wide = {{AW{1'b0}}, rd_ptr_q};

	ccfd_store #(
		.DEPTH (FRAME_STORE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (do_store),
		.waddr (waddr_wide[AW-1:0]),
		.wdata (store_val),
		.raddr (raddr_wide[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			in_frame_q    <= 1'b0;
			code_q        <= 8'd0;
			cnt_q         <= 8'd0;
			crc_q         <= 32'd0;
			fill_q        <= '0;
			rd_ptr_q      <= '0;
			frame_limit_q <= 7'(HARD_LIMIT);
			ovf_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				frame_limit_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!in_frame_q) begin
							fill_q <= '0;
							code_q <= rx_byte;
							crc_q  <= 32'd0;
							cnt_q  <= 8'd0;
							if (rx_byte == 8'd0) begin
								state_q <= ST_EMIT;
							end else begin
								in_frame_q <= 1'b1;
							end
						end else if (rx_byte == 8'd0) begin
							cnt_q      <= cnt_next;
							in_frame_q <= 1'b0;
							rd_ptr_q   <= FILL_W'(HDR_BYTES);
							if (!frame_good) begin
								state_q <= ST_EMIT;
							end else if (fill_q == FILL_W'(MIN_FRAME)) begin
								state_q <= ST_SUM;
							end else begin
								state_q <= ST_RD;
							end
						end else if (code_hit) begin
							code_q <= rx_byte;
							cnt_q  <= 8'd0;
						end else begin
							cnt_q <= cnt_next;
						end
						if (do_store) begin
							fill_q  <= fill_inc;
							crc_q   <= crc_step4(crc_q ^ {24'd0, store_val});
							ovf_q   <= ovf;
							state_q <= ST_CRC;
							if (ovf) begin
								in_frame_q <= 1'b0;
							end
						end
					end
				end
				ST_CRC: begin
					crc_q   <= crc_step4(crc_q);
					state_q <= ovf_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						if (walk_done) begin
							state_q <= ST_SUM;
						end else begin
							rd_ptr_q <= rd_ptr_q + FILL_W'(1);
							state_q  <= ST_RD;
						end
					end
				end
				ST_SUM: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Error code and header bytes travel with the frame; no reset needed.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (!in_frame_q) begin
				err_q <= ERR_DOUBLE_ZERO;
			end else if (rx_byte == 8'd0) begin
				err_q <= ERR_CRC;
			end
		end
		if (do_store) begin
			if (ovf) begin
				err_q <= ERR_OVERFLOW;
			end
			if (fill_q < FILL_W'(HDR_BYTES)) begin
				hdr_q[fill_q[2:0]] <= store_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q        <= KIND_ERROR;
			data_byte_q   <= 8'd0;
			frame_id_q    <= 8'd0;
			timestamp_q   <= 32'd0;
			payload_len_q <= 6'd0;
			error_code_q  <= 2'd0;
			last_q        <= 1'b1;
			case (state_q)
				ST_OUT: begin
					kind_q      <= KIND_DATA;
					data_byte_q <= rd_data;
					last_q      <= 1'b0;
				end
				ST_SUM: begin
					kind_q        <= KIND_SUMMARY;
					frame_id_q    <= hdr_q[0];
					timestamp_q   <= {hdr_q[4], hdr_q[3], hdr_q[2], hdr_q[1]};
					payload_len_q <= 6'(fill_q - FILL_W'(MIN_FRAME));
				end
				default: begin
					error_code_q <= err_q;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign data_byte   = data_byte_q;
	assign frame_id    = frame_id_q;
	assign timestamp   = timestamp_q;
	assign payload_len = payload_len_q;
	assign error_code  = error_code_q;
	assign last        = last_q;

	// The fill count never passes the hard limit of the store.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(HARD_LIMIT))
		else $error("fill count beyond store limit");

	// The walk stays inside the payload part of the frame.
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |->
		(rd_ptr_q >= FILL_W'(HDR_BYTES)) &&
		(rd_ptr_q <= fill_q - FILL_W'(TRAILER_BYTES + 1)))
		else $error("store walk out of payload range");

	// A nonzero code byte outside a frame opens one.
	a_open_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !in_frame_q && (rx_byte != 8'd0)) |=> in_frame_q)
		else $error("code byte did not open a frame");

	// Summaries and errors always close the results of a byte.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (kind_q != KIND_DATA)) |-> last_q)
		else $error("summary or error without last");

	// No result register is overwritten while the receiver stalls.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !emit)
		else $error("result lost under stall");

endmodule

/* design/ccfd_store.sv */
// ----------------------------------------------------------------------------
// ccfd_store: frame store
// Single write port, single read port with a registered read, no reset.
// ----------------------------------------------------------------------------
module ccfd_store import ccfd_pkg::*; #(
	parameter int DEPTH = STORE_DEPTH_DEFAULT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
